// ----- design/plg_pkg.sv -----
package plg_pkg;

    // Fixed widths of the ports.
    localparam int CFG_WIDTH   = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int COUNT_WIDTH = 28;

    localparam logic [CFG_WIDTH-1:0]   MAX_VALUE_RESET = CFG_WIDTH'(100);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = {COUNT_WIDTH{1'b1}};

    // Every run starts testing at this value.
    localparam int FIRST_CANDIDATE = 2;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

// ----- design/plg_divider.sv -----
module plg_divider #(
    parameter int WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  plg_pkg::div_req_t  req,
    input  logic [WIDTH-1:0]   dividend,
    input  logic [WIDTH-1:0]   divisor,
    output plg_pkg::div_rsp_t  rsp,
    output logic [WIDTH-1:0]   quotient,
    output logic [WIDTH-1:0]   remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- design/plg_table.sv -----
module plg_table #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/prime_list_generator.sv -----
// Trial-division prime generator. Each request tests the next candidate,
// counting up from 2 (restart=1 first clears the prime table and count),
// and returns one result: the candidate, its prime flag, the running prime
// count and a done flag once the candidate passes max_value. A request
// tries stored primes in turn on the single bit-serial divider until one
// divides the candidate or one exceeds its square root. The block takes
// one request at a time, and a finished result waits in the output
// register while the next request is taken. Primes past the table depth
// are counted but not stored.
module prime_list_generator #(
    parameter int TABLE_DEPTH = 8192,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [plg_pkg::CFG_WIDTH-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [plg_pkg::OUT_WIDTH-1:0]     m_candidate_value,
    output logic                              m_is_prime,
    output logic [plg_pkg::COUNT_WIDTH-1:0]   m_prime_count,
    output logic                              m_done_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = AW + 1;
    localparam int VW = VALUE_WIDTH;
    localparam int CTW = plg_pkg::COUNT_WIDTH;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [VW-1:0]  max_reg, max_next;
    logic [VW-1:0]  cand_reg, cand_next;
    logic           wrap_reg, wrap_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [CTW-1:0] count_reg, count_next;
    logic [VW-1:0]  n_reg, n_next;
    logic [FW-1:0]  idx_reg, idx_next;
    logic [VW-1:0]  p_reg, p_next;
    logic           prime_reg, prime_next;
    logic           done_reg, done_next;

    logic                    m_valid_reg, m_valid_next;
    logic [plg_pkg::OUT_WIDTH-1:0] out_cand_reg, out_cand_next;
    logic                    out_prime_reg, out_prime_next;
    logic [CTW-1:0]          out_count_reg, out_count_next;
    logic                    out_done_reg, out_done_next;

    logic [VW-1:0]  cfg_masked;
    logic [plg_pkg::OUT_WIDTH-1:0] n_out;

    logic [VW-1:0]  eff_cand;
    logic           eff_wrap;
    logic           tbl_wr_en;
    logic           tbl_rd_en;
    logic [VW-1:0]  tbl_rd_data;

    plg_pkg::div_req_t div_req;
    plg_pkg::div_rsp_t div_rsp;
    logic [VW-1:0]     div_quo;
    logic [VW-1:0]     div_rem;

    // Fit the 32-bit register and result ports to the internal value width.
    generate
        if (VW >= plg_pkg::CFG_WIDTH) begin : g_cfg_wide
            assign cfg_masked = VW'(cfg_wr_data);
        end else begin : g_cfg_narrow
            assign cfg_masked = cfg_wr_data[VW-1:0];
        end
        if (VW >= plg_pkg::OUT_WIDTH) begin : g_out_wide
            assign n_out = n_reg[plg_pkg::OUT_WIDTH-1:0];
        end else begin : g_out_narrow
            assign n_out = plg_pkg::OUT_WIDTH'(n_reg);
        end
    endgenerate

    assign eff_cand = s_restart ? VW'(plg_pkg::FIRST_CANDIDATE) : cand_reg;
    assign eff_wrap = s_restart ? 1'b0 : wrap_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        max_next       = cfg_wr_en ? cfg_masked : max_reg;
        cand_next      = cand_reg;
        wrap_next      = wrap_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        prime_next     = prime_reg;
        done_next      = done_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_cand_next  = out_cand_reg;
        out_prime_next = out_prime_reg;
        out_count_next = out_count_reg;
        out_done_next  = out_done_reg;
        tbl_wr_en      = 1'b0;
        tbl_rd_en      = 1'b0;
        div_req.start  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart) begin
                        cand_next  = VW'(plg_pkg::FIRST_CANDIDATE);
                        wrap_next  = 1'b0;
                        fill_next  = '0;
                        count_next = '0;
                    end
                    n_next     = eff_cand;
                    idx_next   = '0;
                    prime_next = 1'b0;
                    done_next  = eff_wrap || (eff_cand > max_reg);
                    state_next = (eff_wrap || (eff_cand > max_reg)) ? ST_FINISH : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (idx_reg < fill_reg) begin
                    tbl_rd_en  = 1'b1;
                    state_next = ST_LOAD;
                end else begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_LOAD: begin
                p_next        = tbl_rd_data;
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    // p > n/p means p*p > n: no stored divisor is left to try.
                    if (p_reg > div_quo) begin
                        prime_next = 1'b1;
                        state_next = ST_FINISH;
                    end else if (div_rem == '0) begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = idx_reg + FW'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (done_reg) begin
                        out_cand_next  = '0;
                        out_prime_next = 1'b0;
                        out_count_next = count_reg;
                        out_done_next  = 1'b1;
                    end else begin
                        out_cand_next  = n_out;
                        out_prime_next = prime_reg;
                        out_done_next  = 1'b0;
                        out_count_next = count_reg;
                        if (prime_reg) begin
                            if (count_reg != plg_pkg::COUNT_MAX) begin
                                count_next     = count_reg + CTW'(1);
                                out_count_next = count_reg + CTW'(1);
                            end
                            if (fill_reg < FW'(TABLE_DEPTH)) begin
                                tbl_wr_en = 1'b1;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        if (n_reg == {VW{1'b1}}) begin
                            wrap_next = 1'b1;
                        end else begin
                            cand_next = n_reg + VW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            max_reg     <= VW'(plg_pkg::MAX_VALUE_RESET);
            cand_reg    <= VW'(plg_pkg::FIRST_CANDIDATE);
            wrap_reg    <= 1'b0;
            fill_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            max_reg     <= max_next;
            cand_reg    <= cand_next;
            wrap_reg    <= wrap_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        p_reg         <= p_next;
        prime_reg     <= prime_next;
        done_reg      <= done_next;
        out_cand_reg  <= out_cand_next;
        out_prime_reg <= out_prime_next;
        out_count_reg <= out_count_next;
        out_done_reg  <= out_done_next;
    end

    plg_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (n_reg),
        .rd_en   (tbl_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (tbl_rd_data)
    );

    plg_divider #(
        .WIDTH (VW)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .dividend  (n_reg),
        .divisor   (tbl_rd_data),
        .rsp       (div_rsp),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_valid           = m_valid_reg;
    assign m_candidate_value = out_cand_reg;
    assign m_is_prime        = out_prime_reg;
    assign m_prime_count     = out_count_reg;
    assign m_done_res        = out_done_reg;

endmodule

// ----- tb/tb.sv -----
module tb;

    localparam int TABLE_DEPTH = 8192;
    localparam int VALUE_WIDTH = 32;
    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        logic [plg_pkg::OUT_WIDTH-1:0]   candidate_value;
        logic                            is_prime;
        logic [plg_pkg::COUNT_WIDTH-1:0] prime_count;
        logic                            done_res;
    } prime_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [plg_pkg::CFG_WIDTH-1:0]   cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_restart = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic [plg_pkg::OUT_WIDTH-1:0]   m_candidate_value;
    logic                            m_is_prime;
    logic [plg_pkg::COUNT_WIDTH-1:0] m_prime_count;
    logic                            m_done_res;

    // Shadow copy of the generator state.
    logic [plg_pkg::CFG_WIDTH-1:0]   limit_value;
    logic [VALUE_WIDTH:0]            cand_next;
    bit                              cand_wrapped;
    logic [VALUE_WIDTH-1:0]          divisor_table [TABLE_DEPTH];
    int                              table_fill;
    logic [plg_pkg::COUNT_WIDTH-1:0] found_total;

    prime_result_t                   pending_results[$];
    bit                              quiet = 1'b0;
    int                              errors = 0;
    int                              cycle_count = 0;
    int                              requests_sent = 0;
    int                              results_checked = 0;
    int                              primes_seen = 0;
    int                              done_seen = 0;
    logic [plg_pkg::OUT_WIDTH-1:0]   top_candidate = '0;

    prime_list_generator #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_restart         (s_restart),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_candidate_value (m_candidate_value),
        .m_is_prime        (m_is_prime),
        .m_prime_count     (m_prime_count),
        .m_done_res        (m_done_res)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_run();
        cand_next = (VALUE_WIDTH + 1)'(plg_pkg::FIRST_CANDIDATE);
        cand_wrapped = 1'b0;
        table_fill = 0;
        found_total = '0;
    endfunction

    function automatic bit trial_divide(logic [VALUE_WIDTH-1:0] n);
        longint unsigned num;
        longint unsigned p;
        num = 64'(n);
        if (num < plg_pkg::FIRST_CANDIDATE) return 1'b0;
        for (int i = 0; i < table_fill; i++) begin
            p = 64'(divisor_table[i]);
            if (p < 2) continue;
            // Stop once p*p exceeds n; the division form cannot overflow.
            if (p > num / p) break;
            if (num % p == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic prime_result_t predict_step(bit restart);
        prime_result_t r;
        logic [VALUE_WIDTH-1:0] n;
        bit prime;
        if (restart) clear_run();
        r = '0;
        if (cand_wrapped || cand_next > {1'b0, limit_value[VALUE_WIDTH-1:0]}) begin
            r.prime_count = found_total;
            r.done_res = 1'b1;
            return r;
        end
        n = cand_next[VALUE_WIDTH-1:0];
        prime = trial_divide(n);
        if (prime) begin
            if (found_total != plg_pkg::COUNT_MAX) found_total++;
            if (table_fill < TABLE_DEPTH) begin
                divisor_table[table_fill] = n;
                table_fill++;
            end
        end
        if (n == {VALUE_WIDTH{1'b1}}) cand_wrapped = 1'b1;
        else cand_next = {1'b0, n} + 1'b1;
        r.candidate_value = n;
        r.is_prime = prime;
        r.prime_count = found_total;
        return r;
    endfunction

    task automatic send_request(bit restart);
        while (!quiet && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_step(restart));
        requests_sent++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_limit(logic [plg_pkg::CFG_WIDTH-1:0] value);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        limit_value = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_count_from_reset();
        for (int i = 0; i < 8; i++) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_limit_edges();
        // Smallest limit with a prime: one prime, then the run is done.
        write_limit(32'd2);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        // Limits below two are done before the first test.
        write_limit(32'd0);
        send_request(1'b1);
        send_request(1'b0);
        write_limit(32'd1);
        send_request(1'b1);
        write_limit(32'hFFFF_FFFE);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_long_run();
        quiet = 1'b1;
        write_limit(32'hFFFF_FFFF);
        send_request(1'b1);
        for (int i = 0; i < 100; i++) begin
            // Hold the sender once until the pipeline has emptied.
            if (i == 50) wait_for_results();
            send_request(1'b0);
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_mix();
        logic [plg_pkg::CFG_WIDTH-1:0] value;
        int count;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 5))
                0: begin
                    value = $urandom_range(0, 3);
                end
                1: begin
                    value = $urandom_range(2, 40);
                end
                2: begin
                    value = $urandom_range(41, 400);
                end
                3: begin
                    value = 32'hFFFF_FFFE;
                end
                4: begin
                    value = 32'hFFFF_FFFF;
                end
                default: begin
                    value = $urandom;
                end
            endcase
            write_limit(value);
            count = $urandom_range(15, 30);
            send_request(1'($urandom_range(0, 1)));
            for (int i = 1; i < count; i++) send_request($urandom_range(0, 99) < 3);
        end
    endtask

    always @(posedge aclk) begin : result_check
        prime_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: candidate %0d prime %0b count %0d done %0b",
                         $time, m_candidate_value, m_is_prime, m_prime_count, m_done_res);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_candidate_value !== want.candidate_value) begin
                    $display("%0t: candidate_value expected %0d, got %0d",
                             $time, want.candidate_value, m_candidate_value);
                    errors++;
                end
                if (m_is_prime !== want.is_prime) begin
                    $display("%0t: is_prime expected %0b, got %0b",
                             $time, want.is_prime, m_is_prime);
                    errors++;
                end
                if (m_prime_count !== want.prime_count) begin
                    $display("%0t: prime_count expected %0d, got %0d",
                             $time, want.prime_count, m_prime_count);
                    errors++;
                end
                if (m_done_res !== want.done_res) begin
                    $display("%0t: done_res expected %0b, got %0b",
                             $time, want.done_res, m_done_res);
                    errors++;
                end
                results_checked++;
                if (want.is_prime) primes_seen++;
                if (want.done_res) done_seen++;
                if (want.candidate_value > top_candidate) top_candidate = want.candidate_value;
            end
        end
        if (!quiet && $urandom_range(0, 99) < 10) m_ready <= 1'b0;
        else m_ready <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        limit_value = plg_pkg::MAX_VALUE_RESET;
        clear_run();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_count_from_reset();
        test_limit_edges();
        test_long_run();
        test_random_mix();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("Sent %0d requests and checked %0d results in %0d cycles.",
                 requests_sent, results_checked, cycle_count);
        $display("Results held %0d primes and %0d done flags; highest candidate %0d.",
                 primes_seen, done_seen, top_candidate);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
